// ----- rtl/sme_pkg.sv -----
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants of the stack machine execute core
// Opcodes, status codes, field widths and the control groups passed
// between the issue and execute stages.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int OP_W        = 4;
    localparam int WORD_W      = 32;
    localparam int OUT_PC_W    = 16;
    localparam int OUT_CNT_W   = 9;
    localparam int STATUS_W    = 3;

    localparam int MEM_WORDS_DEF   = 1024;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int PC_BITS_DEF     = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_DUP   = 4'd2,
        OP_ADD   = 4'd3,
        OP_MUL   = 4'd4,
        OP_STORE = 4'd5,
        OP_LOAD  = 4'd6,
        OP_LT    = 4'd7,
        OP_JZ    = 4'd8,
        OP_JMP   = 4'd9,
        OP_HALT  = 4'd10,
        OP_SWAP  = 4'd11
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_UNDER   = 3'd3,
        ST_OVER    = 3'd4,
        ST_ADDR    = 3'd5,
        ST_JUMP    = 3'd6
    } t_status;

    // issue stage -> execute stage
    typedef struct packed {
        logic valid;
        logic fwd_stk;
        logic fwd_dm;
        t_op  op;
    } t_stage;

    // execute stage -> issue stage
    typedef struct packed {
        logic take;
        logic clearing;
        logic stk_we;
        logic dm_we;
    } t_exec_ctl;

endpackage

// ----- rtl/sme_if.sv -----
// ----------------------------------------------------------------------------
// sme interfaces: instruction and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface sme_in_if;
    logic                                valid;
    logic                                ready;
    logic [sme_pkg::OP_W-1:0]            op;
    logic signed [sme_pkg::WORD_W-1:0]   immediate;

    modport source (output valid, output op, output immediate, input ready);
    modport sink   (input valid, input op, input immediate, output ready);
endinterface

interface sme_out_if;
    logic                                valid;
    logic                                ready;
    logic [sme_pkg::OUT_PC_W-1:0]        next_pc;
    logic signed [sme_pkg::WORD_W-1:0]   stack_top;
    logic [sme_pkg::OUT_CNT_W-1:0]       stack_count;
    logic [sme_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output next_pc, output stack_top, output stack_count,
                    output status, input ready);
    modport sink   (input valid, input next_pc, input stack_top, input stack_count,
                    input status, output ready);
endinterface

// ----- rtl/sme_ram.sv -----
// ----------------------------------------------------------------------------
// sme_ram: generic single-write, single-read synchronous ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sme_issue.sv -----
// ----------------------------------------------------------------------------
// sme_issue: instruction accept and memory read issue
// Takes an instruction beat, computes the stack and data memory read
// addresses from the running stack pointer, flags same-cycle write hazards
// and holds the instruction for the execute stage.
// ----------------------------------------------------------------------------
module sme_issue #(
    parameter int MEM_WORDS   = sme_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    sme_in_if.sink                                i_in,
    input  sme_pkg::t_exec_ctl                    i_ctl,
    input  logic [$clog2(STACK_DEPTH)-1:0]        i_stk_waddr,
    input  logic [$clog2(MEM_WORDS)-1:0]          i_dm_waddr,
    input  logic [sme_pkg::WORD_W-1:0]            i_wdata,
    output logic                                  o_rd_en,
    output logic [$clog2(STACK_DEPTH)-1:0]        o_stk_raddr,
    output logic [$clog2(MEM_WORDS)-1:0]          o_dm_raddr,
    output sme_pkg::t_stage                       o_stage,
    output logic signed [sme_pkg::WORD_W-1:0]     o_imm,
    output logic [$clog2(STACK_DEPTH)-1:0]        o_rd_addr,
    output logic [sme_pkg::WORD_W-1:0]            o_fwd_data
);

    localparam int SA  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DA  = $clog2(MEM_WORDS);

    logic                          accept;
    sme_pkg::t_op                  op;
    logic [SA-1:0]                 rd_sub;
    logic [SA-1:0]                 rd_addr;
    logic [DA-1:0]                 dm_addr;

    logic [SPW-1:0]                r_sp_a;
    logic [SPW-1:0]                n_sp_a;
    logic                          r_valid;
    sme_pkg::t_op                  r_op;
    logic signed [sme_pkg::WORD_W-1:0] r_imm;
    logic [SA-1:0]                 r_rd_addr;
    logic                          r_fwd_stk;
    logic                          r_fwd_dm;
    logic [sme_pkg::WORD_W-1:0]    r_fwd_data;

    assign i_in.ready = !i_ctl.clearing && (!r_valid || i_ctl.take);
    assign accept     = i_in.valid && i_in.ready;
    assign op         = sme_pkg::t_op'(i_in.op);
    assign dm_addr    = i_in.immediate[DA-1:0];

    // read address is sp-1-k: k is the immediate for pop/dup/swap, else one
    always_comb begin
        if (op == sme_pkg::OP_POP || op == sme_pkg::OP_DUP || op == sme_pkg::OP_SWAP) begin
            rd_sub = i_in.immediate[SA-1:0];
        end else begin
            rd_sub = SA'(1);
        end
        rd_addr = SA'(r_sp_a) - SA'(1) - rd_sub;
    end

    // running stack pointer, assuming the instruction succeeds; after a fault
    // everything is ignored so a wrong guess never matters
    always_comb begin
        unique case (op)
            sme_pkg::OP_PUSH, sme_pkg::OP_DUP, sme_pkg::OP_LOAD: begin
                n_sp_a = r_sp_a + 1'b1;
            end
            sme_pkg::OP_POP: begin
                n_sp_a = i_in.immediate[sme_pkg::WORD_W-1] ? r_sp_a
                                                           : r_sp_a - SPW'(i_in.immediate);
            end
            sme_pkg::OP_ADD, sme_pkg::OP_MUL, sme_pkg::OP_LT,
            sme_pkg::OP_STORE, sme_pkg::OP_JZ, sme_pkg::OP_JMP: begin
                n_sp_a = r_sp_a - 1'b1;
            end
            default: begin
                n_sp_a = r_sp_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp_a  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_sp_a  <= n_sp_a;
                r_valid <= 1'b1;
            end else if (i_ctl.take) begin
                r_valid <= 1'b0;
            end
        end
    end

    // ram reads this cycle miss a write to the same entry landing on this edge
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= op;
            r_imm      <= i_in.immediate;
            r_rd_addr  <= rd_addr;
            r_fwd_stk  <= i_ctl.stk_we && (i_stk_waddr == rd_addr);
            r_fwd_dm   <= i_ctl.dm_we && (i_dm_waddr == dm_addr);
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rd_en      = accept;
    assign o_stk_raddr  = rd_addr;
    assign o_dm_raddr   = dm_addr;
    assign o_stage      = '{valid: r_valid, fwd_stk: r_fwd_stk, fwd_dm: r_fwd_dm, op: r_op};
    assign o_imm        = r_imm;
    assign o_rd_addr    = r_rd_addr;
    assign o_fwd_data   = r_fwd_data;

endmodule

// ----- rtl/sme_exec.sv -----
// ----------------------------------------------------------------------------
// sme_exec: execute, write back and result register
// Holds the committed stack pointer, cached top of stack, program counter
// and halt flag. Completes one instruction per cycle unless the result stalls,
// from the ram read data, writes back to the stack and data memories and loads
// the result register. Also sweeps the data memory to zero after reset.
// ----------------------------------------------------------------------------
module sme_exec #(
    parameter int MEM_WORDS   = sme_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = sme_pkg::PC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sme_pkg::t_stage                       i_stage,
    input  logic signed [sme_pkg::WORD_W-1:0]     i_imm,
    input  logic [$clog2(STACK_DEPTH)-1:0]        i_rd_addr,
    input  logic [sme_pkg::WORD_W-1:0]            i_fwd_data,
    input  logic [sme_pkg::WORD_W-1:0]            i_stk_q,
    input  logic [sme_pkg::WORD_W-1:0]            i_dm_q,
    output sme_pkg::t_exec_ctl                    o_ctl,
    output logic                                  o_stk_we,
    output logic [$clog2(STACK_DEPTH)-1:0]        o_stk_waddr,
    output logic [sme_pkg::WORD_W-1:0]            o_stk_wdata,
    output logic                                  o_dm_we,
    output logic [$clog2(MEM_WORDS)-1:0]          o_dm_waddr,
    output logic [sme_pkg::WORD_W-1:0]            o_dm_wdata,
    sme_out_if.source                             o_out
);

    localparam int SA  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int DA  = $clog2(MEM_WORDS);
    localparam int W   = sme_pkg::WORD_W;

    function automatic logic jump_ok(input logic [W-1:0] t);
        jump_ok = !t[W-1] && ((t >> PC_BITS) == '0);
    endfunction

    logic                     take;
    logic [W-1:0]             stk_rd;
    logic [W-1:0]             dm_rd;
    logic [W-1:0]             imm_u;
    logic [W-1:0]             sp_w;
    logic                     neg;
    logic                     sp_zero;
    logic                     sp_lt2;
    logic                     sp_full;
    logic                     addr_ok;
    logic [W-1:0]             sum_v;
    logic [W-1:0]             prod_v;
    logic [W-1:0]             lt_v;
    logic [W-1:0]             alu_v;
    logic [PC_BITS-1:0]       pc_p1;
    logic [PC_BITS-1:0]       pc_p2;
    logic [SA-1:0]            sp_m1;

    logic [SPW-1:0]           n_sp;
    logic [W-1:0]             n_top;
    logic [PC_BITS-1:0]       n_pc;
    logic                     n_halted;
    sme_pkg::t_status         status;
    logic                     stk_we;
    logic                     swap_wr;
    logic                     dm_we;

    logic [SPW-1:0]           r_sp;
    logic [W-1:0]             r_top;
    logic [PC_BITS-1:0]       r_pc;
    logic                     r_halted;
    logic                     r_clearing;
    logic [DA-1:0]            r_clr_addr;
    logic                     r_out_valid;
    logic [sme_pkg::OUT_PC_W-1:0]  r_out_pc;
    logic [W-1:0]                  r_out_top;
    logic [sme_pkg::OUT_CNT_W-1:0] r_out_cnt;
    sme_pkg::t_status              r_out_status;

    assign take    = i_stage.valid && (!r_out_valid || o_out.ready);
    assign stk_rd  = i_stage.fwd_stk ? i_fwd_data : i_stk_q;
    assign dm_rd   = i_stage.fwd_dm ? i_fwd_data : i_dm_q;
    assign imm_u   = $unsigned(i_imm);
    assign neg     = i_imm[W-1];
    assign sp_w    = W'(r_sp);
    assign sp_zero = (r_sp == '0);
    assign sp_lt2  = (r_sp < SPW'(2));
    assign sp_full = (r_sp == SPW'(STACK_DEPTH));
    assign addr_ok = !neg && (imm_u < W'(MEM_WORDS));
    assign pc_p1   = r_pc + PC_BITS'(1);
    assign pc_p2   = r_pc + PC_BITS'(2);
    assign sp_m1   = SA'(r_sp - 1'b1);

    // top is the left operand, the entry below it the right one
    assign sum_v  = r_top + stk_rd;
    assign prod_v = r_top * stk_rd;
    assign lt_v   = {{(W-1){1'b0}}, ($signed(r_top) < $signed(stk_rd))};

    always_comb begin
        unique case (i_stage.op)
            sme_pkg::OP_ADD: alu_v = sum_v;
            sme_pkg::OP_MUL: alu_v = prod_v;
            default:         alu_v = lt_v;
        endcase
    end

    // the memory holds entries below the top; the top lives in r_top
    always_comb begin
        n_sp    = r_sp;
        n_top   = r_top;
        n_pc    = r_pc;
        status  = sme_pkg::ST_OK;
        stk_we  = 1'b0;
        swap_wr = 1'b0;
        dm_we   = 1'b0;
        if (r_halted) begin
            status = sme_pkg::ST_HALT;
        end else begin
            unique case (i_stage.op)
                sme_pkg::OP_PUSH: begin
                    if (sp_full) begin
                        status = sme_pkg::ST_OVER;
                    end else begin
                        stk_we = !sp_zero;
                        n_sp   = r_sp + 1'b1;
                        n_top  = imm_u;
                        n_pc   = pc_p2;
                    end
                end
                sme_pkg::OP_POP: begin
                    if (!neg && (imm_u > sp_w)) begin
                        status = sme_pkg::ST_UNDER;
                    end else begin
                        if (!neg && (imm_u != '0)) begin
                            n_sp  = r_sp - SPW'(imm_u);
                            n_top = stk_rd;
                        end
                        n_pc = pc_p2;
                    end
                end
                sme_pkg::OP_DUP: begin
                    if (neg || (imm_u >= sp_w)) begin
                        status = sme_pkg::ST_UNDER;
                    end else if (sp_full) begin
                        status = sme_pkg::ST_OVER;
                    end else begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + 1'b1;
                        n_top  = (imm_u == '0) ? r_top : stk_rd;
                        n_pc   = pc_p2;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_MUL, sme_pkg::OP_LT: begin
                    if (sp_lt2) begin
                        status = sme_pkg::ST_UNDER;
                    end else begin
                        n_sp  = r_sp - 1'b1;
                        n_top = alu_v;
                        n_pc  = pc_p1;
                    end
                end
                sme_pkg::OP_STORE: begin
                    if (sp_zero) begin
                        status = sme_pkg::ST_UNDER;
                    end else if (!addr_ok) begin
                        status = sme_pkg::ST_ADDR;
                    end else begin
                        dm_we = 1'b1;
                        n_sp  = r_sp - 1'b1;
                        n_top = stk_rd;
                        n_pc  = pc_p2;
                    end
                end
                sme_pkg::OP_LOAD: begin
                    if (!addr_ok) begin
                        status = sme_pkg::ST_ADDR;
                    end else if (sp_full) begin
                        status = sme_pkg::ST_OVER;
                    end else begin
                        stk_we = !sp_zero;
                        n_sp   = r_sp + 1'b1;
                        n_top  = dm_rd;
                        n_pc   = pc_p2;
                    end
                end
                sme_pkg::OP_JZ: begin
                    if (sp_zero) begin
                        status = sme_pkg::ST_UNDER;
                    end else if (r_top == '0) begin
                        if (!jump_ok(imm_u)) begin
                            status = sme_pkg::ST_JUMP;
                        end else begin
                            n_sp  = r_sp - 1'b1;
                            n_top = stk_rd;
                            n_pc  = PC_BITS'(imm_u);
                        end
                    end else begin
                        n_sp  = r_sp - 1'b1;
                        n_top = stk_rd;
                        n_pc  = pc_p2;
                    end
                end
                sme_pkg::OP_JMP: begin
                    if (sp_zero) begin
                        status = sme_pkg::ST_UNDER;
                    end else if (!jump_ok(r_top)) begin
                        status = sme_pkg::ST_JUMP;
                    end else begin
                        n_sp  = r_sp - 1'b1;
                        n_top = stk_rd;
                        n_pc  = PC_BITS'(r_top);
                    end
                end
                sme_pkg::OP_HALT: begin
                    status = sme_pkg::ST_HALT;
                    n_pc   = pc_p1;
                end
                sme_pkg::OP_SWAP: begin
                    if (!neg && (imm_u != '0)) begin
                        if (imm_u >= sp_w) begin
                            status = sme_pkg::ST_UNDER;
                        end else begin
                            stk_we  = 1'b1;
                            swap_wr = 1'b1;
                            n_top   = stk_rd;
                            n_pc    = pc_p2;
                        end
                    end else begin
                        n_pc = pc_p2;
                    end
                end
                default: begin
                    status = sme_pkg::ST_UNKNOWN;
                end
            endcase
        end
        n_halted = r_halted || (status != sme_pkg::ST_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_pc        <= '0;
            r_halted    <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == DA'(MEM_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (take) begin
                r_sp        <= n_sp;
                r_pc        <= n_pc;
                r_halted    <= n_halted;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_top        <= n_top;
            r_out_pc     <= sme_pkg::OUT_PC_W'(n_pc);
            r_out_top    <= (n_sp == '0) ? '0 : n_top;
            r_out_cnt    <= sme_pkg::OUT_CNT_W'(n_sp);
            r_out_status <= status;
        end
    end

    // outside the reset sweep, both memories are written only with the old top of stack
    assign o_stk_we    = take && stk_we;
    assign o_stk_waddr = swap_wr ? i_rd_addr : sp_m1;
    assign o_stk_wdata = r_top;
    assign o_dm_we     = r_clearing || (take && dm_we);
    assign o_dm_waddr  = r_clearing ? r_clr_addr : i_imm[DA-1:0];
    assign o_dm_wdata  = r_clearing ? '0 : r_top;

    assign o_ctl = '{take: take, clearing: r_clearing, stk_we: take && stk_we,
                     dm_we: take && dm_we};

    assign o_out.valid       = r_out_valid;
    assign o_out.next_pc     = r_out_pc;
    assign o_out.stack_top   = r_out_top;
    assign o_out.stack_count = r_out_cnt;
    assign o_out.status      = r_out_status;

endmodule

// ----- rtl/stack_machine_execute_core.sv -----
// ----------------------------------------------------------------------------
// stack_machine_execute_core: stack machine instruction executor
// Executes one instruction beat per result beat against an operand stack
// ram and a data memory ram, reporting the next fetch address.
// ----------------------------------------------------------------------------
// throughput: one instruction per cycle unless the result channel stalls;
//   the stack and data rams each see one read in the issue cycle and one
//   write in the execute cycle, which also loads the result register
// reset: synchronous; the data memory is then swept to zero with input ready
//   low, stack pointer, pc and halt flag start at zero
// ----------------------------------------------------------------------------
module stack_machine_execute_core #(
    parameter int MEM_WORDS   = sme_pkg::MEM_WORDS_DEF,
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int PC_BITS     = sme_pkg::PC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sme_in_if.sink      i_in,
    sme_out_if.source   o_out
);

    localparam int SA = $clog2(STACK_DEPTH);
    localparam int DA = $clog2(MEM_WORDS);
    localparam int W  = sme_pkg::WORD_W;

    sme_pkg::t_exec_ctl       ctl;
    sme_pkg::t_stage          stage;
    logic                     rd_en;
    logic [SA-1:0]            stk_raddr;
    logic [DA-1:0]            dm_raddr;
    logic signed [W-1:0]      imm;
    logic [SA-1:0]            rd_addr;
    logic [W-1:0]             fwd_data;
    logic [W-1:0]             stk_q;
    logic [W-1:0]             dm_q;
    logic                     stk_we;
    logic [SA-1:0]            stk_waddr;
    logic [W-1:0]             stk_wdata;
    logic                     dm_we;
    logic [DA-1:0]            dm_waddr;
    logic [W-1:0]             dm_wdata;

    sme_issue #(
        .MEM_WORDS   (MEM_WORDS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_issue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .i_stk_waddr (stk_waddr),
        .i_dm_waddr  (dm_waddr),
        .i_wdata     (stk_wdata),
        .o_rd_en     (rd_en),
        .o_stk_raddr (stk_raddr),
        .o_dm_raddr  (dm_raddr),
        .o_stage     (stage),
        .o_imm       (imm),
        .o_rd_addr   (rd_addr),
        .o_fwd_data  (fwd_data)
    );

    sme_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (rd_en),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    sme_ram #(
        .WIDTH (W),
        .DEPTH (MEM_WORDS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (rd_en),
        .i_raddr (dm_raddr),
        .o_rdata (dm_q)
    );

    sme_exec #(
        .MEM_WORDS   (MEM_WORDS),
        .STACK_DEPTH (STACK_DEPTH),
        .PC_BITS     (PC_BITS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (stage),
        .i_imm       (imm),
        .i_rd_addr   (rd_addr),
        .i_fwd_data  (fwd_data),
        .i_stk_q     (stk_q),
        .i_dm_q      (dm_q),
        .o_ctl       (ctl),
        .o_stk_we    (stk_we),
        .o_stk_waddr (stk_waddr),
        .o_stk_wdata (stk_wdata),
        .o_dm_we     (dm_we),
        .o_dm_waddr  (dm_waddr),
        .o_dm_wdata  (dm_wdata),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/sme_checker.sv -----
// ----------------------------------------------------------------------------
// sme_checker: port-level checks for the stack machine execute core
// Watches the result channel over time: sticky halt, empty-stack top,
// result hold under backpressure and input ready right after reset.
// ----------------------------------------------------------------------------
module sme_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_ready,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [sme_pkg::OUT_PC_W-1:0]      i_next_pc,
    input  logic [sme_pkg::WORD_W-1:0]        i_stack_top,
    input  logic [sme_pkg::OUT_CNT_W-1:0]     i_stack_count,
    input  logic [sme_pkg::STATUS_W-1:0]      i_status
);

    logic                              r_halt_seen;
    logic [sme_pkg::OUT_PC_W-1:0]      r_last_pc;
    logic [sme_pkg::OUT_CNT_W-1:0]     r_last_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halt_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && (i_status != sme_pkg::ST_OK)) begin
            r_halt_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_valid && i_out_ready) begin
            r_last_pc  <= i_next_pc;
            r_last_cnt <= i_stack_count;
        end
    end

    // the data memory sweep keeps the input closed right after reset
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready high right after reset");

    a_sticky_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_halt_seen |-> i_status == sme_pkg::ST_HALT)
        else $error("result after halt does not report halted");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_halt_seen |-> i_next_pc == r_last_pc && i_stack_count == r_last_cnt)
        else $error("state moved after halt");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stack_count == '0 |-> i_stack_top == '0)
        else $error("nonzero top on empty stack");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_next_pc, i_stack_top, i_stack_count, i_status}))
        else $error("stalled result beat changed");

endmodule

bind stack_machine_execute_core sme_checker u_sme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_next_pc     (o_out.next_pc),
    .i_stack_top   (o_out.stack_top),
    .i_stack_count (o_out.stack_count),
    .i_status      (o_out.status)
);
